// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante implies cons");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante implies cons next cycle");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/bpa_pkg.sv =====
// Types, constants and field widths for the bitplane pixel access block.
package bpa_pkg;

    localparam int WORD_W          = 16;
    localparam int NUM_BANKS       = 4;
    localparam int BANK_SEL_W      = 2;
    localparam int X_W             = 10;
    localparam int Y_W             = 9;
    localparam int COL_W           = 4;
    localparam int MODE_W          = 2;
    localparam int ROW_CALC_W      = 12;
    localparam int BIT_SEL_W       = 4;
    localparam int STORE_WORDS_DEF = 16384;

    // Words per scan line, and the same in bank rows.
    localparam int LINE_WORDS_LO   = 80;
    localparam int LINE_WORDS_HI   = 40;
    localparam int LINE_ROWS_LO    = LINE_WORDS_LO / NUM_BANKS;
    localparam int LINE_ROWS_HI    = LINE_WORDS_HI / NUM_BANKS;

    localparam logic [WORD_W-1:0] MSB_MASK = 16'h8000;

    localparam logic [X_W-1:0] WIDTH_LO  = 10'd320;
    localparam logic [X_W-1:0] WIDTH_HI  = 10'd640;
    localparam logic [Y_W-1:0] HEIGHT_LO = 9'd200;
    localparam logic [Y_W-1:0] HEIGHT_HI = 9'd400;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOW4  = 2'd0,
        MODE_MED2  = 2'd1,
        MODE_HIGH1 = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_BUSY  = 2'd2
    } t_state;

    // Decoded access: where the plane words lie and whether to touch them.
    typedef struct packed {
        logic                  skip;
        logic                  range_err;
        t_mode                 mode;
        logic [ROW_CALC_W-1:0] row;
        logic [BANK_SEL_W-1:0] base_bank;
        logic [BIT_SEL_W-1:0]  bit_sel;
    } t_access;

endpackage

// ===== sv/bpa_bank.sv =====
// One plane-word bank: one write port, one read port with registered data.
module bpa_bank #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [bpa_pkg::WORD_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [bpa_pkg::WORD_W-1:0] o_rdata
);
    import bpa_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bpa_addr.sv =====
// Coordinate decode: range check, bank row, first bank and bit position.
module bpa_addr (
    input  bpa_pkg::t_mode             i_mode,
    input  logic [bpa_pkg::X_W-1:0]    i_x,
    input  logic [bpa_pkg::Y_W-1:0]    i_y,
    output bpa_pkg::t_access           o_acc
);
    import bpa_pkg::*;

    logic [ROW_CALC_W-1:0] y_lo;
    logic [ROW_CALC_W-1:0] y_hi;
    logic                  err;

    // A word group spans 4 words in low mode and 2 in medium; either way a line is 80 words, so 20 rows.
    assign y_lo = ROW_CALC_W'(i_y) * ROW_CALC_W'(LINE_ROWS_LO);
    assign y_hi = ROW_CALC_W'(i_y) * ROW_CALC_W'(LINE_ROWS_HI);

    always_comb begin
        err             = 1'b0;
        o_acc.skip      = 1'b0;
        o_acc.mode      = i_mode;
        o_acc.bit_sel   = i_x[3:0];
        o_acc.row       = '0;
        o_acc.base_bank = '0;
        unique case (i_mode)
            MODE_LOW4: begin
                err       = (i_x >= WIDTH_LO) || (i_y >= HEIGHT_LO);
                o_acc.row = y_lo + ROW_CALC_W'(i_x[9:4]);
            end
            MODE_MED2: begin
                err             = (i_x >= WIDTH_HI) || (i_y >= HEIGHT_LO);
                o_acc.row       = y_lo + ROW_CALC_W'(i_x[9:5]);
                o_acc.base_bank = {i_x[4], 1'b0};
            end
            MODE_HIGH1: begin
                err             = (i_x >= WIDTH_HI) || (i_y >= HEIGHT_HI);
                o_acc.row       = y_hi + ROW_CALC_W'(i_x[9:6]);
                o_acc.base_bank = i_x[5:4];
            end
            MODE_NONE: begin
                o_acc.skip = 1'b1;
            end
            default: begin
                o_acc.skip = 1'b1;
            end
        endcase
        o_acc.range_err = err;
        if (err) begin
            o_acc.skip = 1'b1;
        end
    end

endmodule

// ===== sv/bitplane_pixel_access.sv =====
// Top level of the bitplane pixel access block: control, banks and result register.
//
// Input stream (i_s_*): one item is a get or set of one pixel; tuser carries the
// action (0 get, 1 set), tdata the coordinate and the colour. Output stream
// (o_m_*): one result per item; tdata holds the colour index read by a get,
// tuser the range error flag. The user writes the mode register through i_cfg_wr_en /
// i_cfg_wr_data only while no item is in flight; the block itself does not enforce it.
// The frame lies in four word banks, word 4*r+b at row r of bank b, so all planes
// of a pixel are read together and later written back together.
// An item goes through the bank read at acceptance, then the modify, write back
// and result load, which wait while the output register is full. The input is
// ready again the cycle after the write back, so no new item is accepted before
// the last one is done; the result is held in the output register until taken.
// After reset the banks are cleared one row per cycle, all ceil(STORE_WORDS/4) rows
// (4096 at the default size); no item is taken until then, mode writes are.
// When the receiver stalls, the finished result waits in the output register;
// one further item is accepted and read, then held until the register frees.
`include "assert_macros.svh"

module bitplane_pixel_access #(
    parameter int STORE_WORDS = bpa_pkg::STORE_WORDS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [bpa_pkg::MODE_W-1:0] i_cfg_wr_data,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [23:0]                i_s_tdata,  // x[9:0], y[18:10], colour[22:19], pad
    input  logic                       i_s_tuser,  // action
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,  // pixel[3:0], pad
    output logic                       o_m_tuser   // range_error
);
    import bpa_pkg::*;

    localparam int BANK_DEPTH = (STORE_WORDS + NUM_BANKS - 1) / NUM_BANKS;
    localparam int ROW_W      = $clog2(BANK_DEPTH);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BANK_DEPTH - 1);

    t_state                 r_state, n_state;
    t_mode                  r_mode;
    logic [ROW_W-1:0]       r_clr_row;
    t_access                r_acc;
    logic                   r_action;
    logic [COL_W-1:0]       r_colour;
    logic                   r_out_valid;
    logic [COL_W-1:0]       r_pixel;
    logic                   r_range_err;

    t_access                acc;
    logic                   accept;
    logic                   done;
    logic [WORD_W-1:0]      mask;
    logic [WORD_W-1:0]      rdata [NUM_BANKS];
    logic [WORD_W-1:0]      wdata [NUM_BANKS];
    logic [NUM_BANKS-1:0]   we;
    logic [ROW_W-1:0]       waddr;
    logic [COL_W-1:0]       pixel_bits;
    logic                   rd_en;

    bpa_addr u_addr (
        .i_mode (r_mode),
        .i_x    (i_s_tdata[9:0]),
        .i_y    (i_s_tdata[18:10]),
        .o_acc  (acc)
    );

    assign accept = i_s_tvalid && o_s_tready;
    assign done   = (r_state == ST_BUSY) && (!r_out_valid || i_m_tready);
    assign rd_en  = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_row == LAST_ROW) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_LOW4;
            r_clr_row <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= t_mode'(i_cfg_wr_data);
            end
            if (r_state == ST_CLEAR) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
            end
        end
    end

    // Hold the decoded item while its bank read is in flight.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc    <= acc;
            r_action <= i_s_tuser;
            r_colour <= i_s_tdata[22:19];
        end
    end

    assign mask = MSB_MASK >> r_acc.bit_sel;

    // Modify: bank b holds plane (b - base_bank) when that plane exists in the mode.
    always_comb begin
        logic [BANK_SEL_W-1:0] plane;
        logic                  used;
        logic [BANK_SEL_W-1:0] bank;
        logic                  in_mode;
        waddr      = (r_state == ST_CLEAR) ? r_clr_row : ROW_W'(r_acc.row);
        pixel_bits = '0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            plane = BANK_SEL_W'(b) - r_acc.base_bank;
            case (r_acc.mode)
                MODE_LOW4:  used = 1'b1;
                MODE_MED2:  used = (plane[1] == 1'b0);
                MODE_HIGH1: used = (plane == '0);
                default:    used = 1'b0;
            endcase
            if (r_state == ST_CLEAR) begin
                we[b]    = 1'b1;
                wdata[b] = '0;
            end else begin
                we[b]    = done && r_action && !r_acc.skip && used;
                wdata[b] = r_colour[plane] ? (rdata[b] | mask) : (rdata[b] & ~mask);
            end
        end
        for (int p = 0; p < COL_W; p++) begin
            bank = r_acc.base_bank + BANK_SEL_W'(p);
            case (r_acc.mode)
                MODE_LOW4:  in_mode = 1'b1;
                MODE_MED2:  in_mode = (p < 2);
                MODE_HIGH1: in_mode = (p < 1);
                default:    in_mode = 1'b0;
            endcase
            pixel_bits[p] = in_mode && ((rdata[bank] & mask) != '0);
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        bpa_bank #(
            .DEPTH (BANK_DEPTH),
            .AW    (ROW_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we[g]),
            .i_waddr (waddr),
            .i_wdata (wdata[g]),
            .i_re    (rd_en),
            .i_raddr (ROW_W'(acc.row)),
            .o_rdata (rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_pixel     <= (r_action || r_acc.skip) ? '0 : pixel_bits;
            r_range_err <= r_acc.range_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_pixel};
    assign o_m_tuser  = r_range_err;

    // An accepted item blocks the next one until its write back is done.
    `ASSERT_NEXT(a_accept_interlock, i_clk, i_rst_n, accept, !o_s_tready)
    // Bank writes never share a cycle with a bank read.
    `ASSERT_IMPLY(a_no_rw_overlap, i_clk, i_rst_n, |we, !rd_en)
    // A flagged coordinate never returns a colour.
    `ASSERT_IMPLY(a_err_pixel_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata[3:0] == 4'd0)

endmodule
